// ----- design/dpalu_pkg.sv -----
package dpalu_pkg;

  // Status codes reported with every result
  typedef enum logic [1:0] {
    STAT_EXEC   = 2'd0,
    STAT_CFAIL  = 2'd1,
    STAT_UNSUP  = 2'd2
  } status_t;

  // Data-processing opcodes, instr[24:21]
  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } opcode_t;

  // Shift types, instr[6:5]
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_type_t;

  localparam logic [3:0] REG_PC      = 4'd15;
  localparam logic [4:0] OP1_MOVS    = 5'b11011;

  typedef struct packed {
    logic [31:0] value;
    logic        carry;
  } shift_res_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        reg_write;
    logic        pc_write;
    logic [3:0]  dest_reg;
    logic [31:0] result_value;
    logic [3:0]  flags;
  } exec_res_t;

endpackage

// ----- design/dpalu_shift.sv -----
module dpalu_shift
  import dpalu_pkg::*;
(
  input  logic [31:0] x,
  input  logic [1:0]  sh_type,
  input  logic [4:0]  imm5,
  input  logic        cin,
  output shift_res_t  sh
);

  logic [32:0] lsl_w;
  logic [32:0] lsr_w;
  logic [32:0] asr_w;
  logic [63:0] ror_w;

  always_comb begin
    lsl_w = {1'b0, x} << imm5;
    lsr_w = {x, 1'b0} >> imm5;
    asr_w = 33'($signed({x, 1'b0}) >>> imm5);
    ror_w = {x, x} >> imm5;
    case (sh_type)
      SH_LSL: begin
        if (imm5 == 5'd0) begin
          sh.value = x;
          sh.carry = cin;
        end else begin
          sh.value = lsl_w[31:0];
          sh.carry = lsl_w[32];
        end
      end
      SH_LSR: begin
        if (imm5 == 5'd0) begin
          sh.value = 32'd0;
          sh.carry = x[31];
        end else begin
          sh.value = lsr_w[32:1];
          sh.carry = lsr_w[0];
        end
      end
      SH_ASR: begin
        if (imm5 == 5'd0) begin
          sh.value = {32{x[31]}};
          sh.carry = x[31];
        end else begin
          sh.value = asr_w[32:1];
          sh.carry = asr_w[0];
        end
      end
      default: begin
        // zero amount encodes RRX
        if (imm5 == 5'd0) begin
          sh.value = {cin, x[31:1]};
          sh.carry = x[0];
        end else begin
          sh.value = ror_w[31:0];
          sh.carry = ror_w[31];
        end
      end
    endcase
  end

endmodule

// ----- design/dpalu_exec.sv -----
module dpalu_exec
  import dpalu_pkg::*;
(
  input  logic [31:0] instr,
  input  logic [31:0] rn,
  input  shift_res_t  sh,
  input  logic [3:0]  flags,
  output exec_res_t   res
);

  logic [3:0]  cond;
  logic [4:0]  op1;
  logic [3:0]  op;
  logic        s_bit;
  logic [3:0]  rd;
  logic        unsup;
  logic        pass;
  logic        cr;
  logic        fn, fz, fc, fv;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_c;
  logic [32:0] sum;
  logic [31:0] alu;
  logic        logical;
  logic        test;
  logic        v_out;

  assign cond  = instr[31:28];
  assign op1   = instr[24:20];
  assign op    = op1[4:1];
  assign s_bit = op1[0];
  assign rd    = instr[15:12];
  assign fn    = flags[3];
  assign fz    = flags[2];
  assign fc    = flags[1];
  assign fv    = flags[0];

  assign unsup = (op == OP_RSC)
              || ((op[3:2] == 2'b10) && !s_bit)
              || ((op1 == OP1_MOVS) && (instr[11:7] == 5'd0)
                  && (instr[6:5] == SH_LSL) && (rd == REG_PC));

  always_comb begin
    case (cond[3:1])
      3'd0:    cr = fz;
      3'd1:    cr = fc;
      3'd2:    cr = fn;
      3'd3:    cr = fv;
      3'd4:    cr = fc && !fz;
      3'd5:    cr = (fn == fv);
      3'd6:    cr = (fn == fv) && !fz;
      default: cr = 1'b1;
    endcase
    if (cond[3:1] == 3'd7) begin
      pass = 1'b1;
    end else begin
      pass = cond[0] ? !cr : cr;
    end
  end

  // Adder operand select
  always_comb begin
    case (op)
      OP_SUB, OP_CMP: begin
        add_a = rn;  add_b = ~sh.value; add_c = 1'b1;
      end
      OP_RSB: begin
        add_a = ~rn; add_b = sh.value;  add_c = 1'b1;
      end
      OP_ADC: begin
        add_a = rn;  add_b = sh.value;  add_c = fc;
      end
      OP_SBC: begin
        add_a = rn;  add_b = ~sh.value; add_c = fc;
      end
      default: begin
        add_a = rn;  add_b = sh.value;  add_c = 1'b0;
      end
    endcase
  end

  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_c};
  assign v_out = (add_a[31] ^ sum[31]) & (add_b[31] ^ sum[31]);

  always_comb begin
    logical = 1'b1;
    test    = 1'b0;
    case (op)
      OP_AND:  alu = rn & sh.value;
      OP_EOR:  alu = rn ^ sh.value;
      OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC: begin
        alu = sum[31:0];
        logical = 1'b0;
      end
      OP_TST: begin
        alu = rn & sh.value;
        test = 1'b1;
      end
      OP_TEQ: begin
        alu = rn ^ sh.value;
        test = 1'b1;
      end
      OP_CMP, OP_CMN: begin
        alu = sum[31:0];
        logical = 1'b0;
        test = 1'b1;
      end
      OP_ORR:  alu = rn | sh.value;
      OP_MOV:  alu = sh.value;
      OP_BIC:  alu = rn & ~sh.value;
      default: alu = ~sh.value;
    endcase
  end

  always_comb begin
    res.status       = STAT_EXEC;
    res.reg_write    = 1'b0;
    res.pc_write     = 1'b0;
    res.dest_reg     = 4'd0;
    res.result_value = 32'd0;
    res.flags        = flags;
    if (unsup) begin
      res.status = STAT_UNSUP;
    end else if (!pass) begin
      res.status = STAT_CFAIL;
    end else begin
      res.result_value = alu;
      if (test || (s_bit && (rd != REG_PC))) begin
        res.flags[3] = alu[31];
        res.flags[2] = (alu == 32'd0);
        res.flags[1] = logical ? sh.carry : sum[32];
        res.flags[0] = logical ? fv : v_out;
      end
      if (!test) begin
        res.reg_write = (rd != REG_PC);
        res.pc_write  = (rd == REG_PC);
        res.dest_reg  = rd;
      end
    end
  end

endmodule

// ----- design/arm_data_processing_register_alu_top.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// input    | in_valid / in_ready  | instr_word, rn_value, rm_value
// output   | out_valid/ out_ready | status, reg_write, pc_write, dest_reg,
//          |                      | result_value, flags_out
//
// An input register feeds the shifter, condition check and ALU, whose answer
// lands in the result register together with the NZCV update, so the next
// instruction sees the new flags with no bubble. One instruction is taken every
// cycle while the output is not stalled.
// Reset clears both valid bits and the flags. A stalled output holds the
// result register; the input register holds too, and in_ready drops only
// when both are full.
module arm_data_processing_register_alu_top
  import dpalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] instr_word,
  input  logic [31:0] rn_value,
  input  logic [31:0] rm_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        reg_write,
  output logic        pc_write,
  output logic [3:0]  dest_reg,
  output logic [31:0] result_value,
  output logic [3:0]  flags_out
);

  // input register
  logic        s1_valid;
  logic [31:0] s1_instr;
  logic [31:0] s1_rn;
  logic [31:0] s1_rm;

  // kept flags, N in bit 3
  logic [3:0]  nzcv;

  logic        advance;
  shift_res_t  sh;
  exec_res_t   ex;

  // Move the staged instruction on whenever the result register is free or
  // being drained this cycle.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // capture the payload on each input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_instr <= instr_word;
      s1_rn    <= rn_value;
      s1_rm    <= rm_value;
    end
  end

  dpalu_shift u_shift (
    .x       (s1_rm),
    .sh_type (s1_instr[6:5]),
    .imm5    (s1_instr[11:7]),
    .cin     (nzcv[1]),
    .sh      (sh)
  );

  dpalu_exec u_exec (
    .instr (s1_instr),
    .rn    (s1_rn),
    .sh    (sh),
    .flags (nzcv),
    .res   (ex)
  );

  // Commit the flags at the same edge the result is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      nzcv <= 4'd0;
    end else if (advance) begin
      nzcv <= ex.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status       <= ex.status;
      reg_write    <= ex.reg_write;
      pc_write     <= ex.pc_write;
      dest_reg     <= ex.dest_reg;
      result_value <= ex.result_value;
      flags_out    <= ex.flags;
    end
  end

  // A skipped or rejected instruction writes nothing and returns zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STAT_EXEC))
      |-> (!reg_write && !pc_write && (dest_reg == 4'd0) && (result_value == 32'd0)))
    else $error("non-executed result carries a write");

  // Never both a general register and the PC.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(reg_write && pc_write))
    else $error("reg_write and pc_write both set");

  // The flags reported with a fresh result are the flags now kept.
  assert property (@(posedge clk) disable iff (rst)
    $past(advance) |-> (flags_out == nzcv))
    else $error("reported flags differ from kept flags");

  // Flags only move when an instruction is committed.
  assert property (@(posedge clk) disable iff (rst)
    !$past(advance) && !$past(rst) |-> $stable(nzcv))
    else $error("flags changed without a commit");

endmodule

// ----- dv/tb_arm_data_processing_register_alu_top.sv -----
`timescale 1ns / 1ps

module tb_arm_data_processing_register_alu_top;
  import dpalu_pkg::*;

  // Condition codes, instr[31:28]
  localparam logic [3:0] COND_EQ = 4'h0, COND_NE = 4'h1, COND_CS = 4'h2, COND_CC = 4'h3;
  localparam logic [3:0] COND_MI = 4'h4, COND_PL = 4'h5, COND_VS = 4'h6, COND_VC = 4'h7;
  localparam logic [3:0] COND_HI = 4'h8, COND_LS = 4'h9, COND_GE = 4'hA, COND_LT = 4'hB;
  localparam logic [3:0] COND_GT = 4'hC, COND_LE = 4'hD, COND_AL = 4'hE, COND_UNCOND = 4'hF;
  localparam logic [3:0] REG_SP = 4'd13;

  // Scoreboard: predicts each instruction's result against its own copy of NZCV
  // and keeps the predictions in transfer order.
  class dp_exec_board;
    exec_res_t  pending_exec[$];
    logic [3:0] nzcv;
    int         errors;

    function new();
      nzcv   = '0;
      errors = 0;
    endfunction

    function logic cond_passes(logic [3:0] cond);
      logic n, z, c, v, hold;
      {n, z, c, v} = nzcv;
      case (cond)
        COND_EQ, COND_NE: hold = z;
        COND_CS, COND_CC: hold = c;
        COND_MI, COND_PL: hold = n;
        COND_VS, COND_VC: hold = v;
        COND_HI, COND_LS: hold = c && !z;
        COND_GE, COND_LT: hold = (n == v);
        COND_GT, COND_LE: hold = (n == v) && !z;
        default: return 1'b1;  // AL and the unconditional space both execute
      endcase
      return cond[0] ? !hold : hold;
    endfunction

    // Immediate-shift decode plus barrel shifter; amount 0 means 32 for LSR/ASR
    // and RRX for ROR.
    function shift_res_t barrel_shift(logic [31:0] x, shift_type_t ty, logic [4:0] amt,
                                      logic cin);
      shift_res_t o;
      int         n;
      n = (amt == 0) ? 32 : int'(amt);
      case (ty)
        SH_LSL: begin
          if (amt == 0) begin
            o.value = x;
            o.carry = cin;
          end else begin
            o.value = x << amt;
            o.carry = x[32 - n];
          end
        end
        SH_LSR: begin
          o.value = (n == 32) ? 32'd0 : x >> n;
          o.carry = x[n - 1];
        end
        SH_ASR: begin
          o.value = (n == 32) ? {32{x[31]}} : 32'($signed(x) >>> n);
          o.carry = x[n - 1];
        end
        default: begin
          if (amt == 0) begin
            o.value = {cin, x[31:1]};
            o.carry = x[0];
          end else begin
            o.value = (x >> n) | (x << (32 - n));
            o.carry = o.value[31];
          end
        end
      endcase
      return o;
    endfunction

    function logic [31:0] sum_carry(logic [31:0] a, logic [31:0] b, logic ci,
                                    output logic co, output logic ov);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b} + {32'd0, ci};
      co  = sum[32];
      ov  = (a[31] ^ sum[31]) & (b[31] ^ sum[31]);
      return sum[31:0];
    endfunction

    function exec_res_t execute(logic [31:0] w, logic [31:0] rn, logic [31:0] rm);
      exec_res_t   r;
      opcode_t     op;
      shift_type_t ty;
      shift_res_t  sh;
      logic [3:0]  cond, rd;
      logic [4:0]  op1, imm5;
      logic [31:0] res;
      logic        s, cin, c, v, logical, test, unsup;
      cond    = w[31:28];
      op1     = w[24:20];
      op      = opcode_t'(op1[4:1]);
      s       = op1[0];
      rd      = w[15:12];
      imm5    = w[11:7];
      ty      = shift_type_t'(w[6:5]);
      cin     = nzcv[1];
      r       = '0;
      res     = '0;
      c       = 1'b0;
      v       = 1'b0;
      logical = 1'b1;
      test    = (op == OP_TST) || (op == OP_TEQ) || (op == OP_CMP) || (op == OP_CMN);
      // RSC, compare/test without S and exception-return MOVS PC are rejected
      unsup = (op == OP_RSC) || (test && !s) ||
              (op1 == OP1_MOVS && imm5 == 0 && ty == SH_LSL && rd == REG_PC);
      if (unsup) begin
        r.status = STAT_UNSUP;
      end else if (!cond_passes(cond)) begin
        r.status = STAT_CFAIL;
      end else begin
        r.status = STAT_EXEC;
        sh = barrel_shift(rm, ty, imm5, cin);
        case (op)
          OP_AND, OP_TST: res = rn & sh.value;
          OP_EOR, OP_TEQ: res = rn ^ sh.value;
          OP_SUB, OP_CMP: begin
            res = sum_carry(rn, ~sh.value, 1'b1, c, v);
            logical = 1'b0;
          end
          OP_RSB: begin
            res = sum_carry(~rn, sh.value, 1'b1, c, v);
            logical = 1'b0;
          end
          OP_ADD, OP_CMN: begin
            res = sum_carry(rn, sh.value, 1'b0, c, v);
            logical = 1'b0;
          end
          OP_ADC: begin
            res = sum_carry(rn, sh.value, cin, c, v);
            logical = 1'b0;
          end
          OP_SBC: begin
            res = sum_carry(rn, ~sh.value, cin, c, v);
            logical = 1'b0;
          end
          OP_ORR: res = rn | sh.value;
          OP_MOV: res = sh.value;
          OP_BIC: res = rn & ~sh.value;
          default: res = ~sh.value;
        endcase
        // A write to the PC never touches the flags, compares always do
        if (test || (s && rd != REG_PC)) begin
          nzcv = {res[31], res == 32'd0, logical ? sh.carry : c, logical ? nzcv[0] : v};
        end
        if (!test) begin
          r.reg_write = (rd != REG_PC);
          r.pc_write  = (rd == REG_PC);
          r.dest_reg  = rd;
        end
        r.result_value = res;
      end
      r.flags = nzcv;
      return r;
    endfunction

    function void take_instr(logic [31:0] w, logic [31:0] rn, logic [31:0] rm);
      pending_exec.push_back(execute(w, rn, rm));
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] got);
      if (exp !== got) begin
        $error("%s: expected %0h, got %0h", name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(exec_res_t got);
      exec_res_t exp;
      if (pending_exec.size() == 0) begin
        $error("result with nothing outstanding: %0h", got);
        errors++;
        return;
      end
      exp = pending_exec.pop_front();
      compare_field("status", 32'(exp.status), 32'(got.status));
      compare_field("reg_write", 32'(exp.reg_write), 32'(got.reg_write));
      compare_field("pc_write", 32'(exp.pc_write), 32'(got.pc_write));
      compare_field("dest_reg", 32'(exp.dest_reg), 32'(got.dest_reg));
      compare_field("result_value", exp.result_value, got.result_value);
      compare_field("flags_out", 32'(exp.flags), 32'(got.flags));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] instr_word = '0;
  logic [31:0] rn_value = '0;
  logic [31:0] rm_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic        reg_write;
  logic        pc_write;
  logic [3:0]  dest_reg;
  logic [31:0] result_value;
  logic [3:0]  flags_out;

  dp_exec_board board = new();
  bit           gaps_on = 1'b1;  // random idling on both channels

  arm_data_processing_register_alu_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .instr_word   (instr_word),
    .rn_value     (rn_value),
    .rm_value     (rm_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .reg_write    (reg_write),
    .pc_write     (pc_write),
    .dest_reg     (dest_reg),
    .result_value (result_value),
    .flags_out    (flags_out)
  );

  always #1 clk = ~clk;

  // Hard stop in case a transfer never completes.
  initial begin
    #200000;
    $display("FAIL arm_data_processing_register_alu_top");
    $finish;
  end

  // Result side: check each transfer against the oldest prediction, then pick
  // the next cycle's ready. Values are sampled as they stood before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_result(exec_res_t'({status, reg_write, pc_write, dest_reg,
                                      result_value, flags_out}));
    end
    out_ready <= !gaps_on || ($urandom_range(99) >= 9);
  end

  function automatic logic [31:0] dp_word(logic [3:0] cond, opcode_t op, logic s,
                                          logic [3:0] rn, logic [3:0] rd, logic [4:0] imm5,
                                          shift_type_t ty, logic [3:0] rm);
    return {cond, 3'b000, op, s, rn, rd, imm5, ty, 1'b0, rm};
  endfunction

  // Present one instruction, optionally after some idle cycles, and hold it
  // until the transfer; valid stays high for a back-to-back successor.
  task automatic send_instr(logic [31:0] w, logic [31:0] rn, logic [31:0] rm);
    while (gaps_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    instr_word <= w;
    rn_value   <= rn;
    rm_value   <= rm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_instr(w, rn, rm);
  endtask

  // Drop valid and hold off until every predicted result has drained.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_exec.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    logic [31:0] corners [5] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1};
    if ($urandom_range(99) < 15) return corners[$urandom_range(4)];
    return $urandom;
  endfunction

  // Mostly executable encodings with random fields; the rest spans all of op1,
  // so rejected encodings and every condition show up too.
  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    int unsigned pick;
    opcode_t     op;
    logic        s;
    w    = $urandom;
    pick = $urandom_range(99);
    if (pick < 45) w[31:28] = COND_AL;
    else if (pick < 55) w[31:28] = COND_UNCOND;
    if ($urandom_range(99) >= 12) begin
      op = opcode_t'($urandom_range(15));
      if (op == OP_RSC) op = OP_MOV;
      s = 1'($urandom_range(1));
      if (op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN) s = 1'b1;
      w[24:20] = {op, s};
    end
    if ($urandom_range(99) < 10) w[15:12] = REG_PC;
    pick = $urandom_range(99);
    if (pick < 25) w[11:7] = 5'd0;
    else if (pick < 35) w[11:7] = 5'd31;
    return w;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: each operation, every shift form and the rejected encodings.
    send_instr(dp_word(COND_AL, OP_MOV, 0, 0, 1, 0, SH_LSL, 2), 0, 0);
    send_instr(dp_word(COND_AL, OP_AND, 1, 1, 2, 0, SH_LSL, 3), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_instr(dp_word(COND_AL, OP_EOR, 1, 1, 2, 31, SH_LSL, 3), 0, 3);
    send_instr(dp_word(COND_AL, OP_SUB, 1, 1, 2, 0, SH_LSL, 3), 0, 1);
    send_instr(dp_word(COND_AL, OP_RSB, 1, 1, 2, 0, SH_LSL, 3), 1, 0);
    send_instr(dp_word(COND_AL, OP_ADD, 1, 1, 2, 0, SH_LSL, 3), 32'h7FFF_FFFF, 1);
    send_instr(dp_word(COND_AL, OP_CMP, 1, 4, 0, 0, SH_LSL, 5), 5, 3);
    send_instr(dp_word(COND_AL, OP_ADC, 1, 1, 2, 0, SH_LSL, 3), 32'hFFFF_FFFF, 0);
    send_instr(dp_word(COND_AL, OP_SBC, 1, 1, 2, 0, SH_LSR, 3), 0, 32'h1234_5678);
    send_instr(dp_word(COND_AL, OP_RSC, 1, 1, 2, 0, SH_LSL, 3), 7, 9);
    send_instr(dp_word(COND_AL, OP_TST, 1, 1, 9, 0, SH_LSL, 3), 32'h0F, 32'hF0);
    send_instr(dp_word(COND_AL, OP_TEQ, 1, 1, 9, 0, SH_ASR, 3), 32'h8000_0000, 32'h8000_0000);
    send_instr(dp_word(COND_AL, OP_CMN, 1, 1, 9, 0, SH_LSL, 3), 32'hFFFF_FFFF, 1);
    send_instr(dp_word(COND_NE, OP_TST, 0, 1, 2, 0, SH_LSL, 3), 1, 1);
    send_instr(dp_word(COND_AL, OP_CMN, 0, 1, 2, 0, SH_LSL, 3), 1, 1);
    send_instr(dp_word(COND_NE, OP_ADD, 0, 1, 2, 0, SH_LSL, 3), 1, 1);
    send_instr(dp_word(COND_AL, OP_ORR, 1, 1, 2, 0, SH_LSR, 3), 0, 32'h8000_0000);
    send_instr(dp_word(COND_AL, OP_MOV, 1, 0, 2, 0, SH_ASR, 3), 0, 32'h8000_0001);
    send_instr(dp_word(COND_AL, OP_BIC, 1, 1, 2, 1, SH_ROR, 3), 32'hFFFF_FFFF, 1);
    send_instr(dp_word(COND_AL, OP_MVN, 1, 0, 2, 0, SH_ROR, 3), 0, 2);
    send_instr(dp_word(COND_AL, OP_MOV, 1, 0, REG_PC, 0, SH_LSL, 3), 0, 32'h100);
    send_instr(dp_word(COND_AL, OP_MOV, 1, 0, REG_PC, 1, SH_LSL, 3), 0, 32'h100);
    send_instr(dp_word(COND_AL, OP_ADD, 0, 1, REG_PC, 0, SH_LSL, 3), 32'h40, 8);
    send_instr(dp_word(COND_AL, OP_ADD, 1, REG_SP, REG_SP, 0, SH_LSL, 3), 32'hFFFF_FFF0, 32'h10);
    send_instr(dp_word(COND_UNCOND, OP_MOV, 1, 0, 3, 31, SH_ROR, 3), 0, 1);
    send_instr(dp_word(COND_AL, OP_MOV, 1, 0, 3, 31, SH_ASR, 3), 0, 32'h7FFF_FFFF);

    // Let the pipe run dry once before the random part.
    drain_results();

    // Random: the middle stretch runs with no idling on either side.
    for (int i = 0; i < 400; i++) begin
      gaps_on = !(i >= 150 && i < 250);
      send_instr(random_instr(), pick_operand(), pick_operand());
    end
    gaps_on = 1'b1;
    in_valid <= 1'b0;

    @(posedge clk);
    while (board.pending_exec.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending_exec.size() == 0) begin
      $display("PASS arm_data_processing_register_alu_top");
    end else begin
      $display("FAIL arm_data_processing_register_alu_top");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/dpalu_pkg.sv
design/dpalu_shift.sv
design/dpalu_exec.sv
design/arm_data_processing_register_alu_top.sv
dv/tb_arm_data_processing_register_alu_top.sv
